// ----- rtl/core/four_digit_display_formatter_assert.svh -----
// assertion macros for the four digit display formatter
`ifndef FOUR_DIGIT_DISPLAY_FORMATTER_ASSERT_SVH
`define FOUR_DIGIT_DISPLAY_FORMATTER_ASSERT_SVH

// antecedent implies consequent in the same cycle, outside reset
`define FDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fdf implication check failed");

// condition holds at every edge outside reset
`define FDF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("fdf invariant check failed");

`endif

// ----- rtl/core/fdf_pkg.sv -----
// shared types and constants for the four digit display formatter
package fdf_pkg;

  typedef enum logic [1:0] {
    CMD_INT   = 2'd0,
    CMD_TEMP  = 2'd1,
    CMD_HUMID = 2'd2,
    CMD_CLOCK = 2'd3
  } cmd_e;

  typedef logic [3:0] sym_t;

  localparam sym_t SYM_BLANK        = 4'd10;
  localparam sym_t SYM_MINUS        = 4'd11;
  localparam sym_t SYM_DEGREE       = 4'd12;
  localparam sym_t SYM_C            = 4'd13;
  localparam sym_t SYM_UNDER_DEGREE = 4'd14;

  localparam logic signed [14:0] INT_MIN  = -15'sd999;
  localparam logic signed [14:0] INT_MAX  = 15'sd9999;
  localparam logic signed [14:0] PAIR_MIN = -15'sd99;
  localparam logic signed [14:0] PAIR_MAX = 15'sd99;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [14:0] value;
    logic               pad_zeros;
    logic [3:0]         dot_mask;
    logic [6:0]         hours;
    logic [6:0]         minutes;
    logic               blink_enable;
    logic               colon_phase;
  } req_t;

  // dig[0] ones ... dig[3] thousands
  typedef struct packed {
    logic [3:0][3:0] dig;
  } bcd_t;

  // sym[0] and dot[0] are the leftmost position
  typedef struct packed {
    sym_t [3:0] sym;
    logic [3:0] dot;
  } res_t;

endpackage

// ----- rtl/core/four_digit_display_formatter.sv -----
// top level of the four digit display formatter: request register, layout, result register
//
//  channel  | direction | payload
//  s_axis   | in        | tuser: command, tdata: value, pad, dots, clock fields
//  m_axis   | out       | tdata: four symbol codes and four dot bits
//
// one word per cycle sustained while m_axis is ready; a word taken sits in the request register,
// then moves to the result register and is on m_axis from then on; a stall on m_axis can hold
// it in either register
// the layout logic between the two registers is a single pass
// reset clears both valid flags; payload registers are not reset
// a stalled m_axis holds its word and backs up into the request register

`include "four_digit_display_formatter_assert.svh"

module four_digit_display_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [14:0] value, [15] pad_zeros, [19:16] dot_mask, [26:20] hours,
  // [33:27] minutes, [34] blink_enable, [35] colon_phase, [39:36] zero
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] symbol_0, [7:4] symbol_1, [11:8] symbol_2, [15:12] symbol_3,
  // [16] dot_0, [17] dot_1, [18] dot_2, [19] dot_3, [23:20] zero
  output logic [23:0] m_axis_tdata_o
);

  logic          req_valid_q, req_valid_d;
  fdf_pkg::req_t req_q, req_d;
  logic          out_valid_q, out_valid_d;
  fdf_pkg::res_t res_q, res_d;
  logic          out_adv;
  logic          in_take;
  logic          sym_ok;

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !req_valid_q || out_adv;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    req_d.cmd          = fdf_pkg::cmd_e'(s_axis_tuser_i);
    req_d.value        = $signed(s_axis_tdata_i[14:0]);
    req_d.pad_zeros    = s_axis_tdata_i[15];
    req_d.dot_mask     = s_axis_tdata_i[19:16];
    req_d.hours        = s_axis_tdata_i[26:20];
    req_d.minutes      = s_axis_tdata_i[33:27];
    req_d.blink_enable = s_axis_tdata_i[34];
    req_d.colon_phase  = s_axis_tdata_i[35];
  end

  assign req_valid_d = s_axis_tready_o ? s_axis_tvalid_i : req_valid_q;
  assign out_valid_d = out_adv ? req_valid_q : out_valid_q;

  fdf_layout u_layout (
    .req_i (req_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= req_d;
    end
    if (out_adv && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q.dot[3], res_q.dot[2], res_q.dot[1], res_q.dot[0],
                            res_q.sym[3], res_q.sym[2], res_q.sym[1], res_q.sym[0]};

  assign sym_ok = (res_q.sym[0] != 4'd15) && (res_q.sym[1] != 4'd15) &&
                  (res_q.sym[2] != 4'd15) && (res_q.sym[3] != 4'd15);

  // input side only stalls when both stages hold a word
  `FDF_ASSERT_IMP(a_stall_full, !s_axis_tready_o, req_valid_q && out_valid_q)
  // a new result word needs a request word in the cycle before
  `FDF_ASSERT_IMP(a_out_from_req, $rose(out_valid_q), $past(req_valid_q))
  // no symbol code above under-degree reaches the output
  `FDF_ASSERT_ALWAYS(a_sym_range, !out_valid_q || sym_ok)

endmodule

// ----- rtl/core/fdf_bcd.sv -----
// splits a magnitude up to 9999 into four decimal digits by reciprocal multiplies
module fdf_bcd (
  input  logic [13:0]   mag_i,
  output fdf_pkg::bcd_t bcd_o
);

  logic [29:0] p10, p100, p1000;
  logic [9:0]  q10;
  logic [6:0]  q100;
  logic [3:0]  q1000;
  logic [13:0] r0;
  logic [9:0]  r1;
  logic [6:0]  r2;

  // floor(x/10), floor(x/100), floor(x/1000) exact for x below 10000
  assign p10   = {16'd0, mag_i} * 30'd52429;
  assign p100  = {16'd0, mag_i} * 30'd5243;
  assign p1000 = {16'd0, mag_i} * 30'd8389;

  assign q10   = p10[28:19];
  assign q100  = p100[25:19];
  assign q1000 = p1000[26:23];

  assign r0 = mag_i - ({1'b0, q10, 3'b000} + {3'b000, q10, 1'b0});
  assign r1 = q10 - ({q100[6:0], 3'b000} + {2'b00, q100[6:0], 1'b0});
  assign r2 = q100 - ({q1000[3:0], 3'b000} + {2'b00, q1000[3:0], 1'b0});

  assign bcd_o.dig[0] = r0[3:0];
  assign bcd_o.dig[1] = r1[3:0];
  assign bcd_o.dig[2] = r2[3:0];
  assign bcd_o.dig[3] = q1000;

endmodule

// ----- rtl/core/fdf_layout.sv -----
// clamps the request and places digits, signs, suffixes and dots on four positions
module fdf_layout (
  input  fdf_pkg::req_t req_i,
  output fdf_pkg::res_t res_o
);

  localparam logic [6:0] PairMax = 7'd99;

  logic signed [14:0] lo, hi, clamped;
  logic               neg;
  logic [14:0]        mag_w;
  logic [13:0]        mag;
  fdf_pkg::bcd_t      bcd;
  logic [1:0]         msd;
  logic               zero;
  logic [7:0]         hr_pair, mn_pair;

  // two digits of a clock pair, saturated at 99
  function automatic logic [7:0] split_pair(input logic [6:0] v);
    logic [6:0]  c;
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    c    = (v > PairMax) ? PairMax : v;
    p    = {8'd0, c} * 15'd205;
    tens = p[14:11];
    ones = c - ({tens, 3'b000} + {2'b00, tens, 1'b0});
    split_pair = {tens, ones[3:0]};
  endfunction

  always_comb begin
    if (req_i.cmd == fdf_pkg::CMD_INT) begin
      lo = fdf_pkg::INT_MIN;
      hi = fdf_pkg::INT_MAX;
    end else begin
      lo = fdf_pkg::PAIR_MIN;
      hi = fdf_pkg::PAIR_MAX;
    end
    if (req_i.value < lo) begin
      clamped = lo;
    end else if (req_i.value > hi) begin
      clamped = hi;
    end else begin
      clamped = req_i.value;
    end
  end

  assign neg   = clamped[14];
  assign mag_w = neg ? (~clamped + 15'd1) : clamped;
  assign mag   = mag_w[13:0];
  assign zero  = (mag == 14'd0);

  fdf_bcd u_bcd (
    .mag_i (mag),
    .bcd_o (bcd)
  );

  // index of the most significant nonzero digit, ones when all are zero
  always_comb begin
    if (bcd.dig[3] != 4'd0) begin
      msd = 2'd3;
    end else if (bcd.dig[2] != 4'd0) begin
      msd = 2'd2;
    end else if (bcd.dig[1] != 4'd0) begin
      msd = 2'd1;
    end else begin
      msd = 2'd0;
    end
  end

  assign hr_pair = split_pair(req_i.hours);
  assign mn_pair = split_pair(req_i.minutes);

  always_comb begin
    res_o.sym = {4{fdf_pkg::SYM_BLANK}};
    res_o.dot = 4'b0000;
    case (req_i.cmd)
      fdf_pkg::CMD_INT: begin
        for (int k = 0; k < 4; k++) begin
          if (req_i.pad_zeros || (2'(k) <= msd)) begin
            res_o.sym[3-k] = bcd.dig[k];
          end
        end
        if (neg) begin
          if (req_i.pad_zeros) begin
            res_o.sym[0] = fdf_pkg::SYM_MINUS;
          end else begin
            // minus goes just left of the leading digit
            case (msd)
              2'd0:    res_o.sym[2] = fdf_pkg::SYM_MINUS;
              2'd1:    res_o.sym[1] = fdf_pkg::SYM_MINUS;
              default: res_o.sym[0] = fdf_pkg::SYM_MINUS;
            endcase
          end
        end
        // unpadded zero shows no dots
        if (req_i.pad_zeros || !zero) begin
          for (int k = 0; k < 4; k++) begin
            res_o.dot[k] = req_i.dot_mask[3-k];
          end
        end
      end
      fdf_pkg::CMD_TEMP, fdf_pkg::CMD_HUMID: begin
        res_o.sym[1] = bcd.dig[0];
        if (req_i.pad_zeros || (bcd.dig[1] != 4'd0)) begin
          res_o.sym[0] = bcd.dig[1];
        end
        if (neg) begin
          res_o.sym[0] = fdf_pkg::SYM_MINUS;
        end
        res_o.sym[2] = fdf_pkg::SYM_DEGREE;
        res_o.sym[3] = (req_i.cmd == fdf_pkg::CMD_TEMP) ? fdf_pkg::SYM_C
                                                         : fdf_pkg::SYM_UNDER_DEGREE;
      end
      fdf_pkg::CMD_CLOCK: begin
        res_o.sym[0] = hr_pair[7:4];
        res_o.sym[1] = hr_pair[3:0];
        res_o.sym[2] = mn_pair[7:4];
        res_o.sym[3] = mn_pair[3:0];
        res_o.dot[1] = req_i.blink_enable ? req_i.colon_phase : 1'b1;
      end
      default: begin
        res_o.sym = {4{fdf_pkg::SYM_BLANK}};
      end
    endcase
  end

endmodule

// ----- tb/tb_four_digit_display_formatter.sv -----
// testbench for the four digit display formatter: directed table, random words, local predictor
module tb_four_digit_display_formatter;
  import fdf_pkg::*;

  localparam int N_RANDOM       = 1025;
  localparam int IDLE_PCT       = 9;
  localparam int CALM_FROM      = 300;
  localparam int CALM_TO        = 500;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_LEN       = 60;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;

  four_digit_display_formatter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct {
    req_t rq;
    bit   typed;
    res_t want;
  } vector_t;

  vector_t dir_tab [$];
  res_t    pending_display [$];

  int   n_sent;
  int   n_checked;
  int   mismatches;
  int   cmd_seen [4];
  int   hold_left;
  bit   hold_done;
  int   held_cycles;
  int   stall_cycles;
  res_t got_word;
  res_t want_word;
  bit   field_bad;
  logic calm;

  assign calm = (n_sent >= CALM_FROM) && (n_sent < CALM_TO);

  // expected display for one request
  function automatic res_t format_display(req_t rq);
    res_t res;
    int   v;
    int   mag;
    int   lo;
    int   hi;
    int   top;
    int   last;
    int   pos;
    int   hr;
    int   mn;
    int   i;
    bit   neg;
    bit   done;
    res.sym = {4{SYM_BLANK}};
    res.dot = '0;
    v = int'(rq.value[14:0]);
    if (rq.value[14]) v = v - 32768;
    if (rq.cmd == CMD_CLOCK) begin
      hr = (rq.hours > 7'd99) ? 99 : int'(rq.hours);
      mn = (rq.minutes > 7'd99) ? 99 : int'(rq.minutes);
      res.sym[0] = sym_t'(hr / 10);
      res.sym[1] = sym_t'(hr % 10);
      res.sym[2] = sym_t'(mn / 10);
      res.sym[3] = sym_t'(mn % 10);
      res.dot[1] = rq.blink_enable ? rq.colon_phase : 1'b1;
    end else begin
      if (rq.cmd == CMD_INT) begin
        lo = -999; hi = 9999; top = 3;
      end else begin
        lo = -99; hi = 99; top = 1;
        res.sym[2] = SYM_DEGREE;
        res.sym[3] = (rq.cmd == CMD_TEMP) ? SYM_C : SYM_UNDER_DEGREE;
      end
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      if (!rq.pad_zeros && v == 0) begin
        res.sym[top] = 4'd0;
      end else begin
        neg  = v < 0;
        mag  = neg ? -v : v;
        last = -1;
        done = 1'b0;
        // fill right to left, stop after the last significant digit unless padding
        for (i = top; i >= 0; i--) begin
          if (!done) begin
            res.sym[i] = (mag != 0 || rq.pad_zeros) ? sym_t'(mag % 10) : SYM_BLANK;
            mag = mag / 10;
            if (mag == 0 && !rq.pad_zeros) begin
              last = i;
              done = 1'b1;
            end
          end
        end
        if (neg) begin
          pos = (last - 1 < 0) ? 0 : last - 1;
          res.sym[pos] = SYM_MINUS;
        end
        if (rq.cmd == CMD_INT)
          for (i = 0; i < 4; i++) res.dot[i] = rq.dot_mask[3 - i];
      end
    end
    return res;
  endfunction

  function automatic req_t mk_req(cmd_e c, int val, bit pad, logic [3:0] mask,
                                  int h, int m, bit bl, bit ph);
    req_t r;
    r.cmd          = c;
    r.value        = val[14:0];
    r.pad_zeros    = pad;
    r.dot_mask     = mask;
    r.hours        = h[6:0];
    r.minutes      = m[6:0];
    r.blink_enable = bl;
    r.colon_phase  = ph;
    return r;
  endfunction

  // dots written left to right, leftmost position in the msb
  function automatic res_t mk_res(sym_t a, sym_t b, sym_t c, sym_t d, logic [3:0] dots);
    res_t r;
    r.sym[0] = a; r.sym[1] = b; r.sym[2] = c; r.sym[3] = d;
    r.dot[0] = dots[3]; r.dot[1] = dots[2]; r.dot[2] = dots[1]; r.dot[3] = dots[0];
    return r;
  endfunction

  function automatic res_t unpack_result(logic [23:0] w);
    res_t r;
    for (int k = 0; k < 4; k++) begin
      r.sym[k] = w[4*k +: 4];
      r.dot[k] = w[16 + k];
    end
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   v;
    int   sel;
    int   corner_vals [17] = '{-16384, 16383, -1000, -999, -998, 9998, 9999, 10000,
                               -100, -99, -98, 98, 99, 100, 0, -1, 1};
    r.cmd = cmd_e'($urandom_range(0, 3));
    sel = $urandom_range(0, 99);
    if (sel < 25)      v = int'($urandom_range(0, 32767)) - 16384;
    else if (sel < 45) v = int'($urandom_range(0, 11200)) - 1100;
    else if (sel < 75) v = int'($urandom_range(0, 240)) - 120;
    else if (sel < 85) v = int'($urandom_range(0, 20)) - 10;
    else               v = corner_vals[$urandom_range(0, 16)];
    r.value        = v[14:0];
    r.pad_zeros    = 1'($urandom_range(0, 1));
    r.dot_mask     = 4'($urandom_range(0, 15));
    r.hours        = 7'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 99)
                                                     : $urandom_range(0, 127));
    r.minutes      = 7'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 99)
                                                     : $urandom_range(0, 127));
    r.blink_enable = 1'($urandom_range(0, 1));
    r.colon_phase  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // offers one word from the next falling edge, returns at the accepting rising edge
  task automatic offer_request(input req_t rq, input res_t want);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, rq.colon_phase, rq.blink_enable, rq.minutes, rq.hours,
                        rq.dot_mask, rq.pad_zeros, rq.value};
    s_axis_tuser_i  <= rq.cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_display.push_back(want);
    cmd_seen[rq.cmd]++;
    n_sent++;
  endtask

  // receiver: random idling, one long hold-off so the block backs up
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
        held_cycles++;
      end else begin
        m_axis_tready_i <= rst_ni && (calm || $urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_word = unpack_result(m_axis_tdata_o);
      if (pending_display.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected word on output: %0d %0d %0d %0d dots %b%b%b%b",
                   got_word.sym[0], got_word.sym[1], got_word.sym[2], got_word.sym[3],
                   got_word.dot[0], got_word.dot[1], got_word.dot[2], got_word.dot[3]);
        mismatches++;
      end else begin
        want_word = pending_display.pop_front();
        field_bad = 1'b0;
        for (int k = 0; k < 4; k++)
          if (got_word.sym[k] !== want_word.sym[k] || got_word.dot[k] !== want_word.dot[k])
            field_bad = 1'b1;
        if (field_bad) begin
          if (mismatches < MAX_REPORTS)
            $display(
              "word %0d: expected %0d %0d %0d %0d dots %b%b%b%b, got %0d %0d %0d %0d dots %b%b%b%b",
              n_checked,
              want_word.sym[0], want_word.sym[1], want_word.sym[2], want_word.sym[3],
              want_word.dot[0], want_word.dot[1], want_word.dot[2], want_word.dot[3],
              got_word.sym[0], got_word.sym[1], got_word.sym[2], got_word.sym[3],
              got_word.dot[0], got_word.dot[1], got_word.dot[2], got_word.dot[3]);
          mismatches++;
        end
        n_checked++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no word moved for %0d cycles, %0d results outstanding",
               stall_cycles, pending_display.size());
      $display("tb_four_digit_display_formatter failed");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_INT;

    // integer: zero, saturation, minus placement, dot mask
    dir_tab.push_back('{mk_req(CMD_INT, 0, 0, 4'hf, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_BLANK, SYM_BLANK, SYM_BLANK, 0, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_INT, 0, 1, 4'hf, 0, 0, 0, 0), 1'b1,
                        mk_res(0, 0, 0, 0, 4'b1111)});
    dir_tab.push_back('{mk_req(CMD_INT, 16383, 0, 4'h0, 127, 127, 1, 1), 1'b1,
                        mk_res(9, 9, 9, 9, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_INT, -999, 0, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_MINUS, 9, 9, 9, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_INT, -16384, 0, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_MINUS, 9, 9, 9, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_INT, -999, 1, 4'hf, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_MINUS, 9, 9, 9, 4'b1111)});
    dir_tab.push_back('{mk_req(CMD_INT, -5, 1, 4'h5, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_MINUS, 0, 0, 5, 4'b0101)});
    dir_tab.push_back('{mk_req(CMD_INT, -5, 0, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_BLANK, SYM_BLANK, SYM_MINUS, 5, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_INT, 7, 0, 4'h8, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_BLANK, SYM_BLANK, SYM_BLANK, 7, 4'b1000)});
    dir_tab.push_back('{mk_req(CMD_INT, 42, 1, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(0, 0, 4, 2, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_INT, -1, 0, 4'h1, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_BLANK, SYM_BLANK, SYM_MINUS, 1, 4'b0001)});
    // temperature and humidity: zero, saturation, tens digit lost to the minus
    dir_tab.push_back('{mk_req(CMD_TEMP, 0, 0, 4'hf, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_BLANK, 0, SYM_DEGREE, SYM_C, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_TEMP, 0, 1, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(0, 0, SYM_DEGREE, SYM_C, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_TEMP, 99, 0, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(9, 9, SYM_DEGREE, SYM_C, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_TEMP, 16383, 1, 4'hf, 0, 0, 0, 0), 1'b1,
                        mk_res(9, 9, SYM_DEGREE, SYM_C, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_TEMP, -45, 0, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_MINUS, 5, SYM_DEGREE, SYM_C, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_TEMP, -5, 0, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_MINUS, 5, SYM_DEGREE, SYM_C, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_TEMP, -5, 1, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_MINUS, 5, SYM_DEGREE, SYM_C, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_HUMID, -16384, 0, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_MINUS, 9, SYM_DEGREE, SYM_UNDER_DEGREE, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_HUMID, 7, 0, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(SYM_BLANK, 7, SYM_DEGREE, SYM_UNDER_DEGREE, 4'b0000)});
    // clock: leading zeros, saturation, colon steady and blinking
    dir_tab.push_back('{mk_req(CMD_CLOCK, 0, 0, 4'h0, 0, 0, 0, 0), 1'b1,
                        mk_res(0, 0, 0, 0, 4'b0100)});
    dir_tab.push_back('{mk_req(CMD_CLOCK, 0, 0, 4'h0, 127, 127, 1, 0), 1'b1,
                        mk_res(9, 9, 9, 9, 4'b0000)});
    dir_tab.push_back('{mk_req(CMD_CLOCK, -16384, 1, 4'hf, 12, 34, 1, 1), 1'b1,
                        mk_res(1, 2, 3, 4, 4'b0100)});
    dir_tab.push_back('{mk_req(CMD_INT, 1234, 0, 4'ha, 0, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{mk_req(CMD_HUMID, 63, 1, 4'h3, 99, 58, 1, 0), 1'b0, '0});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[n])
      offer_request(dir_tab[n].rq,
                    dir_tab[n].typed ? dir_tab[n].want : format_display(dir_tab[n].rq));
    repeat (N_RANDOM) begin
      req_t rq;
      rq = random_request();
      offer_request(rq, format_display(rq));
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (pending_display.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("words in: %0d (integer %0d, temperature %0d, humidity %0d, clock %0d)",
             n_sent, cmd_seen[CMD_INT], cmd_seen[CMD_TEMP], cmd_seen[CMD_HUMID],
             cmd_seen[CMD_CLOCK]);
    $display("words out checked: %0d, output held off %0d cycles, mismatches: %0d",
             n_checked, held_cycles, mismatches);
    if (mismatches == 0)
      $display("tb_four_digit_display_formatter passed");
    else
      $display("tb_four_digit_display_formatter failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/fdf_pkg.sv
rtl/core/fdf_bcd.sv
rtl/core/fdf_layout.sv
rtl/core/four_digit_display_formatter.sv
tb/tb_four_digit_display_formatter.sv
